/* sv/ocpm_pkg.sv */
// Shared types and constants for the opposite-charge pair mass cut unit.
// No dependencies; imported by every module of the block.
package ocpm_pkg;

  localparam int OCPM_MAX_OBJECTS  = 16;
  localparam int OCPM_MAX_TRACKS   = 16;
  localparam int OCPM_MOMENTUM_BITS = 24;

  localparam int FIELD_W = 24;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_PAIR_LOW  = 3'd0,
    REG_PAIR_HIGH = 3'd1,
    REG_LOW_MASS  = 3'd2,
    REG_Z_LOW     = 3'd3,
    REG_Z_HIGH    = 3'd4,
    REG_ON_Z      = 3'd5
  } reg_idx_t;

  // configuration as seen by the evaluator
  typedef struct packed {
    logic signed [5:0] pair_count_low;
    logic signed [5:0] pair_count_high;
    logic [23:0]       low_mass_cut;
    logic [23:0]       z_window_low;
    logic [23:0]       z_window_high;
    logic              on_z_required;
  } cfg_t;

  // classification of one queued word
  typedef struct packed {
    logic is_trk;
    logic pos;
    logic neg;
    logic last;
  } item_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_OUT
  } back_state_t;

endpackage

/* sv/opposite_charge_pair_mass_cut_unit.sv */
// Top level of the opposite-charge pair mass cut unit: config port and wiring.
// Depends on ocpm_pkg, ocpm_front and ocpm_back.
//
// Usage: items (objects, command 0, or tracks, command 1) enter on the input
// channel (in_valid/in_stall); the item with last_item set closes the event
// and one result word (pass_cut, pair_count, z_pair_count, overflow) leaves
// on the output channel (out_valid/out_stall). Other items give no word.
// A two-word queue sits between the front end and the evaluator, so up to
// two input words are taken while the evaluator works or the result waits.
// The evaluator moves each queued item into its store while it is loading.
// After the closing item, the bound check runs; unless it fails or finds no
// pairs, the pair walk then issues one object-track pair per cycle (all
// obj_fill * trk_fill pairs) through a 5-stage datapath, and the result is
// posted once the datapath has drained.
// Reset empties the queue, stores and counts and loads the register defaults.
// While out_stall holds, the result word stays put; the next event loads
// normally but its result waits until the output register is taken.
// Registers are written over the APB-style port, 4 bytes apart.
module opposite_charge_pair_mass_cut_unit
  import ocpm_pkg::*;
#(
  parameter int MAX_OBJECTS   = OCPM_MAX_OBJECTS,
  parameter int MAX_TRACKS    = OCPM_MAX_TRACKS,
  parameter int MOMENTUM_BITS = OCPM_MOMENTUM_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic signed [1:0]         charge,
  input  logic signed [FIELD_W-1:0] energy,
  input  logic signed [FIELD_W-1:0] mom_x,
  input  logic signed [FIELD_W-1:0] mom_y,
  input  logic signed [FIELD_W-1:0] mom_z,
  input  logic                      last_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      pass_cut,
  output logic [4:0]                pair_count,
  output logic [8:0]                z_pair_count,
  output logic                      overflow
);

  cfg_t       cfg;
  logic       q_valid, q_pop;
  item_ctl_t  q_ctl;
  logic [MOMENTUM_BITS-1:0] q_e, q_px, q_py, q_pz;
  reg_idx_t   widx;
  logic       wr_en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pair_count_low  <= -6'sd1;
      cfg.pair_count_high <= -6'sd1;
      cfg.low_mass_cut    <= 24'd0;
      cfg.z_window_low    <= 24'd76000;
      cfg.z_window_high   <= 24'd106000;
      cfg.on_z_required   <= 1'b0;
    end else if (wr_en) begin
      unique case (widx)
        REG_PAIR_LOW:  cfg.pair_count_low  <= pwdata[5:0];
        REG_PAIR_HIGH: cfg.pair_count_high <= pwdata[5:0];
        REG_LOW_MASS:  cfg.low_mass_cut    <= pwdata[23:0];
        REG_Z_LOW:     cfg.z_window_low    <= pwdata[23:0];
        REG_Z_HIGH:    cfg.z_window_high   <= pwdata[23:0];
        REG_ON_Z:      cfg.on_z_required   <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (widx)
      REG_PAIR_LOW:  prdata = DATA_W'($unsigned(cfg.pair_count_low));
      REG_PAIR_HIGH: prdata = DATA_W'($unsigned(cfg.pair_count_high));
      REG_LOW_MASS:  prdata = DATA_W'(cfg.low_mass_cut);
      REG_Z_LOW:     prdata = DATA_W'(cfg.z_window_low);
      REG_Z_HIGH:    prdata = DATA_W'(cfg.z_window_high);
      REG_ON_Z:      prdata = DATA_W'(cfg.on_z_required);
      default:       prdata = '0;
    endcase
  end

  ocpm_front #(
    .MOMENTUM_BITS(MOMENTUM_BITS)
  ) u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .charge, .energy,
    .mom_x, .mom_y, .mom_z, .last_item,
    .q_valid, .q_pop, .q_ctl, .q_e, .q_px, .q_py, .q_pz
  );

  ocpm_back #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .MAX_TRACKS(MAX_TRACKS),
    .MOMENTUM_BITS(MOMENTUM_BITS)
  ) u_back (
    .clk, .rst, .cfg,
    .q_valid, .q_pop, .q_ctl, .q_e, .q_px, .q_py, .q_pz,
    .out_valid, .out_stall, .pass_cut, .pair_count, .z_pair_count, .overflow
  );

endmodule

/* sv/ocpm_front.sv */
// Front end: accepts input words, classifies them and queues them.
// Depends on ocpm_pkg.
module ocpm_front
  import ocpm_pkg::*;
#(
  parameter int MOMENTUM_BITS = OCPM_MOMENTUM_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic signed [1:0]         charge,
  input  logic signed [FIELD_W-1:0] energy,
  input  logic signed [FIELD_W-1:0] mom_x,
  input  logic signed [FIELD_W-1:0] mom_y,
  input  logic signed [FIELD_W-1:0] mom_z,
  input  logic                      last_item,
  output logic                      q_valid,
  input  logic                      q_pop,
  output item_ctl_t                 q_ctl,
  output logic [MOMENTUM_BITS-1:0]  q_e,
  output logic [MOMENTUM_BITS-1:0]  q_px,
  output logic [MOMENTUM_BITS-1:0]  q_py,
  output logic [MOMENTUM_BITS-1:0]  q_pz
);

  localparam int MB = MOMENTUM_BITS;

  item_ctl_t        ctl_q [2];
  logic [MB-1:0]    e_q   [2];
  logic [MB-1:0]    px_q  [2];
  logic [MB-1:0]    py_q  [2];
  logic [MB-1:0]    pz_q  [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  item_ctl_t        ctl_in;

  // classify: zero charge counts with the negatives
  always_comb begin
    ctl_in.is_trk = command;
    ctl_in.pos    = ~charge[1] & charge[0];
    ctl_in.neg    = charge[1];
    ctl_in.last   = last_item;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (count != 2'd0);

  // two-word queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue payload; low momentum bits taken from the raw field
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr] <= ctl_in;
      e_q[wr_ptr]   <= MB'($unsigned(energy));
      px_q[wr_ptr]  <= MB'($unsigned(mom_x));
      py_q[wr_ptr]  <= MB'($unsigned(mom_y));
      pz_q[wr_ptr]  <= MB'($unsigned(mom_z));
    end
  end

  assign q_ctl = ctl_q[rd_ptr];
  assign q_e   = e_q[rd_ptr];
  assign q_px  = px_q[rd_ptr];
  assign q_py  = py_q[rd_ptr];
  assign q_pz  = pz_q[rd_ptr];

endmodule

/* sv/ocpm_back.sv */
// Back end: object/track stores, charge counts, pipelined pair walk, result word.
// Depends on ocpm_pkg.
module ocpm_back
  import ocpm_pkg::*;
#(
  parameter int MAX_OBJECTS   = OCPM_MAX_OBJECTS,
  parameter int MAX_TRACKS    = OCPM_MAX_TRACKS,
  parameter int MOMENTUM_BITS = OCPM_MOMENTUM_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  item_ctl_t                q_ctl,
  input  logic [MOMENTUM_BITS-1:0] q_e,
  input  logic [MOMENTUM_BITS-1:0] q_px,
  input  logic [MOMENTUM_BITS-1:0] q_py,
  input  logic [MOMENTUM_BITS-1:0] q_pz,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     pass_cut,
  output logic [4:0]               pair_count,
  output logic [8:0]               z_pair_count,
  output logic                     overflow
);

  localparam int MB     = MOMENTUM_BITS;
  localparam int ENT_W  = 4 * MB + 2;
  localparam int OF_W   = $clog2(MAX_OBJECTS + 1);
  localparam int TF_W   = $clog2(MAX_TRACKS + 1);
  localparam int OI_W   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int TI_W   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int NP_W   = $clog2(MAX_OBJECTS + MAX_TRACKS + 1);
  localparam int NZ_W   = $clog2(MAX_OBJECTS * MAX_TRACKS + 1);
  localparam int SQ_W   = 2 * MB + 2;
  localparam int PP_W   = SQ_W + 2;
  localparam int CW     = ((PP_W > 48) ? PP_W : 48) + 1;

  back_state_t state, state_next;

  // stores
  logic [ENT_W-1:0] obj_mem [MAX_OBJECTS];
  logic [ENT_W-1:0] trk_mem [MAX_TRACKS];
  logic [ENT_W-1:0] rd_obj, rd_trk;
  logic [ENT_W-1:0] wr_ent;

  logic [OF_W-1:0]  obj_fill, n_obj_pos, n_obj_neg;
  logic [TF_W-1:0]  trk_fill, n_trk_pos, n_trk_neg;
  logic             ovf;

  logic [OI_W-1:0]  oi;
  logic [TI_W-1:0]  tj;
  logic             last_pair;

  logic [NP_W-1:0]  npairs, npairs_r;
  logic             bound_fail;
  logic             chk_ok;
  logic             failed;
  logic [NZ_W-1:0]  nz;

  logic             issue, res_load;
  logic             obj_room, trk_room;

  // pipeline
  logic                 p1_v, p2_v, p3_v, p4_v, p5_v;
  logic                 p2_skip, p3_skip, p4_skip, p5_skip;
  logic signed [MB:0]   s_e, s_x, s_y, s_z;
  logic [SQ_W-1:0]      sq_e, sq_x, sq_y, sq_z;
  logic [SQ_W-1:0]      e2_4;
  logic [PP_W-1:0]      pp_4;
  logic                 low_fail_5, z_in_5;
  logic [47:0]          lc2, zl2, zh2;
  logic signed [2*MB+1:0] m_e, m_x, m_y, m_z;

  assign wr_ent   = {q_e, q_px, q_py, q_pz, q_ctl.pos, q_ctl.neg};
  assign obj_room = (obj_fill < OF_W'(MAX_OBJECTS));
  assign trk_room = (trk_fill < TF_W'(MAX_TRACKS));

  // pair count from the charge counts and the bound check
  always_comb begin
    logic [NP_W-1:0] m1, m2;
    m1 = (NP_W'(n_obj_pos) < NP_W'(n_trk_neg)) ? NP_W'(n_obj_pos) : NP_W'(n_trk_neg);
    m2 = (NP_W'(n_obj_neg) < NP_W'(n_trk_pos)) ? NP_W'(n_obj_neg) : NP_W'(n_trk_pos);
    npairs     = m1 + m2;
    bound_fail = 1'b0;
    if (!cfg.pair_count_low[5] && (32'(npairs) < 32'(cfg.pair_count_low[4:0])))
      bound_fail = 1'b1;
    if (!cfg.pair_count_high[5] && (32'(npairs) > 32'(cfg.pair_count_high[4:0])))
      bound_fail = 1'b1;
  end

  assign last_pair = ((OF_W'(oi) + OF_W'(1)) == obj_fill) &&
                     ((TF_W'(tj) + TF_W'(1)) == trk_fill);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (q_valid && q_ctl.last) state_next = ST_CHECK;
      ST_CHECK: state_next = (bound_fail || npairs == '0) ? ST_OUT : ST_WALK;
      ST_WALK:  if (last_pair) state_next = ST_DRAIN;
      ST_DRAIN: if (!(p1_v | p2_v | p3_v | p4_v | p5_v)) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || !out_stall) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = (state == ST_LOAD) && q_valid;
    issue    = (state == ST_WALK);
    res_load = (state == ST_OUT) && (!out_valid || !out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      obj_fill  <= '0;
      trk_fill  <= '0;
      n_obj_pos <= '0;
      n_obj_neg <= '0;
      n_trk_pos <= '0;
      n_trk_neg <= '0;
      ovf       <= 1'b0;
      oi        <= '0;
      tj        <= '0;
      failed    <= 1'b0;
      nz        <= '0;
      chk_ok    <= 1'b0;
      npairs_r  <= '0;
      out_valid <= 1'b0;
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0; p4_v <= 1'b0; p5_v <= 1'b0;
    end else begin
      state <= state_next;

      // loading a word into its store
      if (q_pop) begin
        if (!q_ctl.is_trk) begin
          if (obj_room) begin
            obj_fill <= obj_fill + OF_W'(1);
            if (q_ctl.pos) n_obj_pos <= n_obj_pos + OF_W'(1);
            else           n_obj_neg <= n_obj_neg + OF_W'(1);
          end else begin
            ovf <= 1'b1;
          end
        end else begin
          if (trk_room) begin
            trk_fill <= trk_fill + TF_W'(1);
            if (q_ctl.pos) n_trk_pos <= n_trk_pos + TF_W'(1);
            else           n_trk_neg <= n_trk_neg + TF_W'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
      end

      if (state == ST_CHECK) begin
        npairs_r <= npairs;
        chk_ok   <= ~bound_fail;
        failed   <= 1'b0;
        nz       <= '0;
        oi       <= '0;
        tj       <= '0;
      end

      // pair walk counters, object-major
      if (issue) begin
        if ((TF_W'(tj) + TF_W'(1)) == trk_fill) begin
          tj <= '0;
          oi <= oi + OI_W'(1);
        end else begin
          tj <= tj + TI_W'(1);
        end
      end

      p1_v <= issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;

      // in-order consumption; nothing counts after a low-mass fail
      if (p5_v && !p5_skip && !failed) begin
        if (low_fail_5)  failed <= 1'b1;
        else if (z_in_5) nz <= nz + NZ_W'(1);
      end

      // result word and end-of-event clear
      if (res_load) begin
        out_valid <= 1'b1;
        obj_fill  <= '0;
        trk_fill  <= '0;
        n_obj_pos <= '0;
        n_obj_neg <= '0;
        n_trk_pos <= '0;
        n_trk_neg <= '0;
        ovf       <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      pass_cut     <= chk_ok && ((npairs_r == '0) ||
                      (!failed && (cfg.on_z_required ? (nz != '0) : (nz == '0))));
      pair_count   <= 5'(npairs_r);
      z_pair_count <= 9'(nz);
      overflow     <= ovf;
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (q_pop && !q_ctl.is_trk && obj_room) obj_mem[obj_fill[OI_W-1:0]] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_ctl.is_trk && trk_room) trk_mem[trk_fill[TI_W-1:0]] <= wr_ent;
  end

  // registered store reads
  always_ff @(posedge clk) begin
    rd_obj <= obj_mem[oi];
    rd_trk <= trk_mem[tj];
  end

  // squared mass thresholds
  always_ff @(posedge clk) begin
    lc2 <= cfg.low_mass_cut * cfg.low_mass_cut;
    zl2 <= cfg.z_window_low * cfg.z_window_low;
    zh2 <= cfg.z_window_high * cfg.z_window_high;
  end

  assign m_e = s_e * s_e;
  assign m_x = s_x * s_x;
  assign m_y = s_y * s_y;
  assign m_z = s_z * s_z;

  // pair datapath: sums, squares, momentum sum, compares
  always_ff @(posedge clk) begin
    s_e <= (MB+1)'($signed(rd_obj[4*MB+1:3*MB+2])) + (MB+1)'($signed(rd_trk[4*MB+1:3*MB+2]));
    s_x <= (MB+1)'($signed(rd_obj[3*MB+1:2*MB+2])) + (MB+1)'($signed(rd_trk[3*MB+1:2*MB+2]));
    s_y <= (MB+1)'($signed(rd_obj[2*MB+1:MB+2]))   + (MB+1)'($signed(rd_trk[2*MB+1:MB+2]));
    s_z <= (MB+1)'($signed(rd_obj[MB+1:2]))        + (MB+1)'($signed(rd_trk[MB+1:2]));
    p2_skip <= (rd_obj[1] & rd_trk[1]) | (rd_obj[0] & rd_trk[0]);

    sq_e <= $unsigned(m_e);
    sq_x <= $unsigned(m_x);
    sq_y <= $unsigned(m_y);
    sq_z <= $unsigned(m_z);
    p3_skip <= p2_skip;

    e2_4 <= sq_e;
    pp_4 <= PP_W'(sq_x) + PP_W'(sq_y) + PP_W'(sq_z);
    p4_skip <= p3_skip;

    low_fail_5 <= CW'(e2_4) < (CW'(pp_4) + CW'(lc2));
    z_in_5     <= (CW'(e2_4) > (CW'(pp_4) + CW'(zl2))) &&
                  (CW'(e2_4) < (CW'(pp_4) + CW'(zh2)));
    p5_skip <= p4_skip;
  end

endmodule

/* sv/ocpm_checker.sv */
// Port-level checks for the opposite-charge pair mass cut unit, bound to the top.
// Depends on ocpm_pkg and opposite_charge_pair_mass_cut_unit.
module ocpm_checker
  import ocpm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       out_valid,
  input logic       out_stall,
  input logic       pass_cut,
  input logic [4:0] pair_count,
  input logic [8:0] z_pair_count,
  input logic       overflow
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pass_cut) &&
    $stable(pair_count) && $stable(z_pair_count) && $stable(overflow))
    else $error("result word changed while stalled");

  // no result straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word after reset");

  // no Z pairs reported when the reported pair count is zero
  a_zero_pairs: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_count == 5'd0 |-> z_pair_count == 9'd0)
    else $error("Z pairs reported with zero pair count");

  // slave never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind opposite_charge_pair_mass_cut_unit ocpm_checker u_ocpm_checker (
  .clk, .rst, .pready, .out_valid, .out_stall, .pass_cut,
  .pair_count, .z_pair_count, .overflow
);
